// ----- hdl/shape_spec_byte_validator_core_macros.svh -----
// Assertion macros shared by the shape spec-byte validator RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef SHAPE_SPEC_BYTE_VALIDATOR_CORE_MACROS_SVH
`define SHAPE_SPEC_BYTE_VALIDATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sbv_pkg.sv -----
// Types and constants for the shape spec-byte validator.
// No dependencies; imported by sbv_decode, the top level and the bench files.
package sbv_pkg;

    // Command numbers; the end code doubles as "no command pending".
    typedef enum logic [3:0] {
        CMD_END       = 4'd0,
        CMD_PEN_DOWN  = 4'd1,
        CMD_PEN_UP    = 4'd2,
        CMD_DIV_SCALE = 4'd3,
        CMD_MUL_SCALE = 4'd4,
        CMD_PUSH      = 4'd5,
        CMD_POP       = 4'd6,
        CMD_SUBSHAPE  = 4'd7,
        CMD_LINE      = 4'd8,
        CMD_MULTILINE = 4'd9,
        CMD_OCTARC    = 4'd10,
        CMD_FRACARC   = 4'd11,
        CMD_ARC       = 4'd12,
        CMD_MULTIARC  = 4'd13,
        CMD_DONEXT    = 4'd14,
        CMD_ZERO_VEC  = 4'd15
    } cmd_t;

    // Verdict codes; codes 3..15 equal the offending command number.
    typedef enum logic [3:0] {
        ERR_NONE         = 4'd0,
        ERR_LAST_NONZERO = 4'd1,
        ERR_EARLY_END    = 4'd2,
        ERR_DIV_SCALE    = 4'd3,
        ERR_MUL_SCALE    = 4'd4,
        ERR_PUSH         = 4'd5,
        ERR_POP          = 4'd6,
        ERR_SUBSHAPE     = 4'd7,
        ERR_LINE         = 4'd8,
        ERR_MULTILINE    = 4'd9,
        ERR_OCTARC       = 4'd10,
        ERR_FRACARC      = 4'd11,
        ERR_ARC          = 4'd12,
        ERR_MULTIARC     = 4'd13,
        ERR_DONEXT       = 4'd14,
        ERR_ZERO_VEC     = 4'd15
    } err_t;

    // Phase within a coordinate pair of multi-line / multi-arc.
    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_SECOND = 2'd1,
        PH_BULGE = 2'd2,
        PH_UNUSED = 2'd3
    } phase_t;

    localparam logic [2:0] MAX_STACK_DEPTH = 3'd4;

    localparam logic [2:0] OPS_ONE   = 3'd1;
    localparam logic [2:0] OPS_TWO   = 3'd2;
    localparam logic [2:0] OPS_THREE = 3'd3;
    localparam logic [2:0] OPS_FIVE  = 3'd5;
    localparam logic [2:0] OPS_NONE  = 3'd0;

    typedef struct packed {
        logic [2:0] stack_depth;
        cmd_t       pending_cmd;
        logic [2:0] operands_left;
        phase_t     pair_phase;
        logic       pair_first_zero;
        logic       do_next_pending;
        err_t       first_error;
    } sbv_state_t;

    localparam sbv_state_t SHAPE_CLEAR = '{
        stack_depth:     3'd0,
        pending_cmd:     CMD_END,
        operands_left:   OPS_NONE,
        pair_phase:      PH_FIRST,
        pair_first_zero: 1'b0,
        do_next_pending: 1'b0,
        first_error:     ERR_NONE
    };

endpackage

// ----- hdl/sbv_decode.sv -----
// Per-byte decoder: next shape state and verdict for one spec byte.
// Depends on sbv_pkg; purely combinational.
module sbv_decode (
    input  sbv_pkg::sbv_state_t state_cur,
    input  logic [7:0]          spec_byte,
    input  logic                last_byte,
    input  logic                unicode_mode,
    output sbv_pkg::sbv_state_t state_next,
    output sbv_pkg::err_t       verdict
);
    import sbv_pkg::*;

    sbv_state_t st;
    err_t       fe;
    cmd_t       cmd;
    logic       is_small;
    logic       takes_ops;
    logic [2:0] count;
    logic [2:0] ops_dec;

    assign cmd      = cmd_t'(spec_byte[3:0]);
    assign is_small = (spec_byte[7:4] == 4'd0);
    assign ops_dec  = (state_cur.operands_left != OPS_NONE)
                      ? state_cur.operands_left - 3'd1 : OPS_NONE;

    always_comb begin
        st = state_cur;
        st.do_next_pending = 1'b0;
        fe = state_cur.first_error;
        takes_ops = 1'b0;
        count = OPS_NONE;

        // Do-next target landing on the last byte.
        if (state_cur.do_next_pending && last_byte && fe == ERR_NONE) begin
            fe = ERR_DONEXT;
        end

        if (state_cur.pending_cmd != CMD_END) begin
            // Operand byte of the pending command.
            if (last_byte && fe == ERR_NONE) begin
                fe = err_t'(state_cur.pending_cmd);
            end
            if (state_cur.pending_cmd == CMD_MULTILINE ||
                state_cur.pending_cmd == CMD_MULTIARC) begin
                if (state_cur.pair_phase == PH_FIRST) begin
                    st.pair_first_zero = (spec_byte == 8'd0);
                    st.pair_phase = PH_SECOND;
                end else if (state_cur.pair_phase == PH_SECOND) begin
                    if (state_cur.pair_first_zero && spec_byte == 8'd0) begin
                        st.pending_cmd = CMD_END;
                        st.pair_phase = PH_FIRST;
                    end else begin
                        st.pair_phase = (state_cur.pending_cmd == CMD_MULTIARC)
                                        ? PH_BULGE : PH_FIRST;
                    end
                end else begin
                    st.pair_phase = PH_FIRST;
                end
            end else begin
                st.operands_left = ops_dec;
                if (ops_dec == OPS_NONE) begin
                    st.pending_cmd = CMD_END;
                end
            end
        end else if (is_small) begin
            unique case (cmd)
                CMD_END: begin
                    if (!last_byte && fe == ERR_NONE) begin
                        fe = ERR_EARLY_END;
                    end
                end
                CMD_PEN_DOWN, CMD_PEN_UP: begin
                end
                CMD_DIV_SCALE, CMD_MUL_SCALE: begin
                    takes_ops = 1'b1;
                    count = OPS_ONE;
                end
                CMD_PUSH: begin
                    if (state_cur.stack_depth >= MAX_STACK_DEPTH) begin
                        if (fe == ERR_NONE) fe = ERR_PUSH;
                    end else begin
                        st.stack_depth = state_cur.stack_depth + 3'd1;
                    end
                end
                CMD_POP: begin
                    if (state_cur.stack_depth == 3'd0) begin
                        if (fe == ERR_NONE) fe = ERR_POP;
                    end else begin
                        st.stack_depth = state_cur.stack_depth - 3'd1;
                    end
                end
                CMD_SUBSHAPE: begin
                    takes_ops = 1'b1;
                    count = unicode_mode ? OPS_TWO : OPS_ONE;
                end
                CMD_LINE, CMD_OCTARC: begin
                    takes_ops = 1'b1;
                    count = OPS_TWO;
                end
                CMD_MULTILINE, CMD_MULTIARC: begin
                    takes_ops = 1'b1;
                    count = OPS_NONE;
                end
                CMD_FRACARC: begin
                    takes_ops = 1'b1;
                    count = OPS_FIVE;
                end
                CMD_ARC: begin
                    takes_ops = 1'b1;
                    count = OPS_THREE;
                end
                CMD_DONEXT: begin
                    if (last_byte) begin
                        if (fe == ERR_NONE) fe = ERR_DONEXT;
                    end else begin
                        st.do_next_pending = 1'b1;
                    end
                end
                CMD_ZERO_VEC: begin
                    if (fe == ERR_NONE) fe = ERR_ZERO_VEC;
                end
            endcase
            if (takes_ops) begin
                if (last_byte && fe == ERR_NONE) begin
                    fe = err_t'(cmd);
                end
                st.pending_cmd = cmd;
                st.operands_left = count;
                st.pair_phase = PH_FIRST;
                st.pair_first_zero = 1'b0;
            end
        end

        st.first_error = fe;
        verdict = (spec_byte != 8'd0) ? ERR_LAST_NONZERO : fe;
        state_next = last_byte ? SHAPE_CLEAR : st;
    end

endmodule

// ----- hdl/shape_spec_byte_validator_core.sv -----
// Shape spec-byte validator, top level: handshakes, shape state, result register.
// Depends on sbv_pkg, sbv_decode and shape_spec_byte_validator_core_macros.svh.
//
//  channel | dir | tdata                        | tlast
//  --------+-----+------------------------------+--------------------------
//  s_      | in  | [7:0] spec_byte              | last_byte
//  m_      | out | [3:0] error_code, [7:4] zero | shape_done (always 1)
//  cfg_    | in  | cfg_wdata: unicode_mode      | -
//
// One item per cycle: each accepted byte updates the shape state in the
// same clock edge, and the verdict is registered into the result register
// when the last byte is accepted. The state update is a single decoder pass
// between the state registers and the result register. A waiting verdict
// stalls input only while m_tready is low. Synchronous active-low reset
// clears the shape state, the result valid flag and unicode_mode.
module shape_spec_byte_validator_core (
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration
    input  logic       cfg_wen,
    input  logic       cfg_wdata,   // [0] unicode_mode
    // Input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] spec_byte
    input  logic       s_tlast,     // last_byte
    // Result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [3:0] error_code, [7:4] zero
    output logic       m_tlast      // shape_done
);
    import sbv_pkg::*;
    `include "shape_spec_byte_validator_core_macros.svh"

    sbv_state_t state_reg;
    sbv_state_t state_next;
    err_t       verdict;
    err_t       code_reg;
    logic       m_valid_reg;
    logic       unicode_reg;
    logic       s_fire;

    // Accept while the result register is empty or being drained.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    sbv_decode u_decode (
        .state_cur    (state_reg),
        .spec_byte    (s_tdata),
        .last_byte    (s_tlast),
        .unicode_mode (unicode_reg),
        .state_next   (state_next),
        .verdict      (verdict)
    );

    // Configuration register: take bit 0 on every write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unicode_reg <= 1'b0;
        end else if (cfg_wen) begin
            unicode_reg <= cfg_wdata;
        end
    end

    // Shape state: advance on every accepted byte, clear after the last one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SHAPE_CLEAR;
        end else if (s_fire) begin
            state_reg <= state_next;
        end
    end

    // Result register: load the verdict on the last byte, drop it once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire && s_tlast) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_tlast) begin
            code_reg <= verdict;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, code_reg};
    assign m_tlast  = 1'b1;

    // Checks on the shape state and the verdict path.
    `SBV_ASSERT_NOW(a_depth_limit, aclk, aresetn, 1'b1,
        state_reg.stack_depth <= MAX_STACK_DEPTH, "stack depth above limit")
    `SBV_ASSERT_NOW(a_ops_need_cmd, aclk, aresetn, state_reg.operands_left != OPS_NONE,
        state_reg.pending_cmd != CMD_END, "operands counted with no pending command")
    `SBV_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, s_fire && s_tlast,
        state_reg == SHAPE_CLEAR && m_valid_reg, "shape state not cleared after last byte")
    `SBV_ASSERT_NEXT(a_nonzero_last, aclk, aresetn, s_fire && s_tlast && s_tdata != 8'd0,
        code_reg == ERR_LAST_NONZERO, "nonzero last byte did not give its verdict")

endmodule

// ----- bench/shape_spec_byte_validator_checker.sv -----
`timescale 1ns / 100ps
// Checker for shape_spec_byte_validator_core: watches the config write, the spec-byte
// stream and the verdict stream, predicts each verdict and compares. Depends on sbv_pkg.
module shape_spec_byte_validator_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wen,
    input  logic       cfg_wdata,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    output int         fail_count,
    output int         verdicts_pending,
    output int         verdicts_checked
);
    import sbv_pkg::*;

    // Shadow of the per-shape decoder state and the mode register.
    logic       mode_unicode;
    logic [2:0] depth;
    cmd_t       open_cmd;
    logic [2:0] ops_left;
    phase_t     pair_phase;
    logic       pair_zero;
    logic       donext_armed;
    err_t       first_err;

    err_t       verdict_q[$];
    err_t       want;

    function void clear_shape();
        depth        = 3'd0;
        open_cmd     = CMD_END;
        ops_left     = 3'd0;
        pair_phase   = PH_FIRST;
        pair_zero    = 1'b0;
        donext_armed = 1'b0;
        first_err    = ERR_NONE;
    endfunction

    function void note_err(input err_t code);
        if (first_err == ERR_NONE)
            first_err = code;
    endfunction

    function void consume_operand(input logic [7:0] b);
        if (open_cmd == CMD_MULTILINE || open_cmd == CMD_MULTIARC) begin
            case (pair_phase)
                PH_FIRST: begin
                    pair_zero  = (b == 8'h00);
                    pair_phase = PH_SECOND;
                end
                PH_SECOND: begin
                    if (pair_zero && b == 8'h00) begin
                        open_cmd   = CMD_END;
                        pair_phase = PH_FIRST;
                    end else if (open_cmd == CMD_MULTIARC) begin
                        pair_phase = PH_BULGE;
                    end else begin
                        pair_phase = PH_FIRST;
                    end
                end
                default: pair_phase = PH_FIRST;
            endcase
        end else begin
            if (ops_left != 3'd0)
                ops_left = ops_left - 3'd1;
            if (ops_left == 3'd0)
                open_cmd = CMD_END;
        end
    endfunction

    function void decode_command(input logic [7:0] b, input logic last);
        logic [2:0] count;
        logic       has_ops;
        cmd_t       c;
        count   = 3'd0;
        has_ops = 1'b0;
        c       = cmd_t'(b[3:0]);
        // packed vectors (0x10 and up) move the pen and touch no state
        if (b[7:4] == 4'h0) begin
            case (c)
                CMD_END:                       if (!last) note_err(ERR_EARLY_END);
                CMD_PEN_DOWN, CMD_PEN_UP:      ;
                CMD_DIV_SCALE, CMD_MUL_SCALE:  begin count = 3'd1; has_ops = 1'b1; end
                CMD_PUSH: begin
                    // overflow keeps the depth pinned at the limit
                    if (depth >= MAX_STACK_DEPTH) note_err(ERR_PUSH);
                    else depth = depth + 3'd1;
                end
                CMD_POP: begin
                    if (depth == 3'd0) note_err(ERR_POP);
                    else depth = depth - 3'd1;
                end
                CMD_SUBSHAPE: begin
                    count   = mode_unicode ? 3'd2 : 3'd1;
                    has_ops = 1'b1;
                end
                CMD_LINE, CMD_OCTARC:          begin count = 3'd2; has_ops = 1'b1; end
                CMD_MULTILINE, CMD_MULTIARC:   has_ops = 1'b1;
                CMD_FRACARC:                   begin count = 3'd5; has_ops = 1'b1; end
                CMD_ARC:                       begin count = 3'd3; has_ops = 1'b1; end
                CMD_DONEXT: begin
                    if (last) note_err(ERR_DONEXT);
                    else donext_armed = 1'b1;
                end
                default:                       note_err(ERR_ZERO_VEC);
            endcase
        end
        if (has_ops) begin
            // operands would fall past the end of the shape
            if (last) note_err(err_t'(c));
            open_cmd   = c;
            ops_left   = count;
            pair_phase = PH_FIRST;
            pair_zero  = 1'b0;
        end
    endfunction

    // Advance the shape by one spec byte; queue the verdict on the last byte.
    function void advance_shape(input logic [7:0] b, input logic last);
        if (donext_armed && last)
            note_err(ERR_DONEXT);
        donext_armed = 1'b0;
        if (open_cmd != CMD_END) begin
            if (last) note_err(err_t'(open_cmd));
            consume_operand(b);
        end else begin
            decode_command(b, last);
        end
        if (last) begin
            verdict_q.insert(verdict_q.size(),
                             (b != 8'h00) ? ERR_LAST_NONZERO : first_err);
            clear_shape();
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_shape();
            mode_unicode = 1'b0;
            verdict_q.delete();
            fail_count       = 0;
            verdicts_checked = 0;
        end else begin
            if (cfg_wen)
                mode_unicode = cfg_wdata;
            // compare first: a verdict never leaves in the cycle its byte enters
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    $error("verdict with no shape open: error_code %0d", m_tdata[3:0]);
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    verdicts_checked++;
                    if (m_tdata[3:0] !== want) begin
                        $error("error_code mismatch: expected %0d, actual %0d",
                               want, m_tdata[3:0]);
                        fail_count++;
                    end
                    if (m_tlast !== 1'b1) begin
                        $error("shape_done mismatch: expected 1, actual %b", m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                advance_shape(s_tdata, s_tlast);
        end
        verdicts_pending = verdict_q.size();
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Top of the bench for shape_spec_byte_validator_core: clock, reset, shape stimulus,
// idle/stall phases and the verdict. Depends on sbv_pkg and the checker module.
module testbench;
    import sbv_pkg::*;

    localparam int ITEMS_PER_PHASE = 410;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 400;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_wen;
    logic       cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] spec_byte
    logic       s_tlast;    // last_byte
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [3:0] error_code, [7:4] zero
    logic       m_tlast;    // shape_done

    int fail_count;
    int verdicts_pending;
    int verdicts_checked;

    int cycle_count     = 0;
    int send_idle_pct   = 0;
    int stall_pct       = 0;
    int hold_off_cycles = 0;
    int bytes_sent      = 0;
    int phase_bytes     = 0;
    logic unicode_now   = 1'b0;

    // spec bytes of the shape being built; the final entry goes out with tlast
    logic [7:0] shape_q[$];

    always #5 aclk = ~aclk;

    shape_spec_byte_validator_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    shape_spec_byte_validator_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .verdicts_pending(verdicts_pending),
        .verdicts_checked(verdicts_checked)
    );

    // Abort a hung run; the limit is far beyond the slowest legal run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: a pending hold-off request drops tready for a long stretch,
    // counted down here; otherwise stall at the phase's rate.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                m_tready <= 1'b0;
                hold_off_cycles = hold_off_cycles - 1;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic [7:0] cmd_byte(input cmd_t c);
        return {4'h0, c};
    endfunction

    // Add one byte at the tail of the shape being built.
    function automatic void append_byte(input logic [7:0] b);
        shape_q.insert(shape_q.size(), b);
    endfunction

    // Operand bytes lean toward zero so zero pairs and zero bulges show up.
    function automatic logic [7:0] rand_operand();
        logic [7:0] v;
        v = 8'($urandom_range(255));
        if ($urandom_range(3) == 0) v = 8'h00;
        return v;
    endfunction

    function automatic int operand_count(input cmd_t c);
        case (c)
            CMD_DIV_SCALE, CMD_MUL_SCALE: return 1;
            CMD_SUBSHAPE:                 return unicode_now ? 2 : 1;
            CMD_LINE, CMD_OCTARC:         return 2;
            CMD_FRACARC:                  return 5;
            CMD_ARC:                      return 3;
            default:                      return 0;
        endcase
    endfunction

    // Offer one item at the falling edge after a random idle gap; hold it until taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        bytes_sent++;
        phase_bytes++;
    endtask

    task automatic send_shape();
        int i;
        for (i = 0; i < shape_q.size(); i++)
            send_byte(shape_q[i], i == shape_q.size() - 1);
    endtask

    // Build a mostly legal shape: commands with the right operand counts, pair runs
    // closed by a zero pair, push/pop and do-next left to chance, closed by the end code.
    task automatic make_valid_shape();
        int         n_cmds;
        cmd_t       c;
        logic [7:0] x;
        logic [7:0] y;
        n_cmds = $urandom_range(1, 8);
        repeat (n_cmds) begin
            if ($urandom_range(99) < 25) begin
                x = 8'($urandom_range(8'hFF, 8'h10));
                append_byte(x);
            end else begin
                c = cmd_t'($urandom_range(14, 1));
                append_byte(cmd_byte(c));
                if (c == CMD_MULTILINE || c == CMD_MULTIARC) begin
                    repeat ($urandom_range(3)) begin
                        x = rand_operand();
                        y = rand_operand();
                        if (x == 8'h00 && y == 8'h00) y = 8'h01;
                        append_byte(x);
                        append_byte(y);
                        if (c == CMD_MULTIARC) append_byte(rand_operand());
                    end
                    append_byte(8'h00);
                    append_byte(8'h00);
                end else begin
                    repeat (operand_count(c)) append_byte(rand_operand());
                end
            end
        end
        append_byte(cmd_byte(CMD_END));
    endtask

    // Mostly legal shapes; the rest are cut short or plain noise.
    task automatic make_random_shape();
        int         pick;
        int         drop;
        int         len;
        logic [7:0] v;
        shape_q.delete();
        pick = $urandom_range(99);
        if (pick < 75) begin
            make_valid_shape();
        end else if (pick < 90) begin
            make_valid_shape();
            drop = $urandom_range(3, 1);
            while (drop > 0 && shape_q.size() > 1) begin
                void'(shape_q.pop_back());
                drop--;
            end
        end else begin
            len = $urandom_range(10, 1);
            repeat (len) begin
                v = 8'($urandom_range(255));
                if ($urandom_range(1)) v = 8'($urandom_range(15));
                append_byte(v);
            end
            if ($urandom_range(1)) shape_q[shape_q.size() - 1] = 8'h00;
        end
    endtask

    task automatic write_mode(input logic v);
        cfg_wen     <= 1'b1;
        cfg_wdata   <= v;
        unicode_now  = v;
        @(negedge aclk);
        cfg_wen     <= 1'b0;
    endtask

    // Drop valid, wait out every open verdict, then let the pipe settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (verdicts_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Corner shapes: extreme bytes, stack limits, early end, do-next and
    // operands landing on the last byte, zero vector, zero-pair runs.
    task automatic run_corner_shapes();
        shape_q = {8'hFF};
        send_shape();
        shape_q = {cmd_byte(CMD_END), cmd_byte(CMD_END)};
        send_shape();
        shape_q = {cmd_byte(CMD_PUSH), cmd_byte(CMD_PUSH), cmd_byte(CMD_PUSH),
                   cmd_byte(CMD_PUSH), cmd_byte(CMD_PUSH), cmd_byte(CMD_END)};
        send_shape();
        shape_q = {cmd_byte(CMD_POP), cmd_byte(CMD_END)};
        send_shape();
        shape_q = {cmd_byte(CMD_DONEXT), cmd_byte(CMD_END)};
        send_shape();
        shape_q = {cmd_byte(CMD_ZERO_VEC), cmd_byte(CMD_END)};
        send_shape();
        // a scale command as the last byte: the nonzero last byte wins
        shape_q = {cmd_byte(CMD_DIV_SCALE)};
        send_shape();
        shape_q = {cmd_byte(CMD_MUL_SCALE), 8'hFF, cmd_byte(CMD_LINE), 8'h00, 8'h00,
                   cmd_byte(CMD_MULTILINE), 8'h00, 8'h00,
                   cmd_byte(CMD_MULTIARC), 8'h00, 8'h00, cmd_byte(CMD_END)};
        send_shape();
    endtask

    initial begin
        int p;
        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // phases: no idling, sender idle, receiver stalling, both
        for (p = 0; p < 4; p++) begin
            case (p)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 65; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 65; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            write_mode(p[0]);
            phase_bytes = 0;
            if (p == 0) begin
                run_corner_shapes();
                // stop taking verdicts while bytes keep coming, so input backs up
                hold_off_cycles = HOLD_OFF_CYCLES;
            end
            while (phase_bytes < ITEMS_PER_PHASE) begin
                make_random_shape();
                send_shape();
            end
            drain();
        end

        repeat (10) @(negedge aclk);
        $display("summary: %0d spec bytes, %0d shape verdicts checked", bytes_sent,
                 verdicts_checked);
        $display("summary: both subshape modes, four idle/stall mixes, one long hold-off");
        if (fail_count == 0 && verdicts_pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
